>>> rtl/tam_pkg.sv
// Shared types, sizes and constants for the three-axis trimmed-mean block.
// Used by tam_div, tam_scale and three_axis_trimmed_mean.
package tam_pkg;

    localparam int WINDOW   = 1024;                  // samples per window
    localparam int SMP_W    = 16;                    // raw sample width
    localparam int CNT_W    = $clog2(WINDOW + 1);    // sample count
    localparam int SUM_W    = SMP_W + 1 + $clog2(WINDOW);
    localparam int TRIM_W   = SUM_W + 1;             // sum less both extremes
    localparam int OUT_W    = 19;                    // milli-g result width
    localparam int CFG_W    = 5;
    localparam int MG_NUM   = 10000;
    localparam int MG_SHIFT = 15;                    // divide by 32768
    localparam int GAIN_W   = CFG_W + $clog2(MG_NUM);
    localparam int PROD_W   = OUT_W + GAIN_W + 1;
    localparam int DIV_CNT_W = $clog2(TRIM_W);
    localparam int FS_RESET = 2;
    localparam int MIN_SAMPLES = 3;

    localparam int IN_TDATA_W  = 3 * SMP_W;
    localparam int OUT_TDATA_W = ((6 * OUT_W + 7) / 8) * 8;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(2 ** (OUT_W - 1));
    localparam logic [PROD_W-1:0] MG_ROUND = PROD_W'((2 ** MG_SHIFT) - 1);

    typedef struct packed {
        logic                     start;
        logic signed [TRIM_W-1:0] dividend;
        logic [CNT_W-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [SMP_W:0] mag16(input logic signed [SMP_W-1:0] v);
        logic signed [SMP_W:0] e;
        e = {v[SMP_W-1], v};
        return v[SMP_W-1] ? (SMP_W + 1)'(-e) : (SMP_W + 1)'(e);
    endfunction

endpackage

>>> rtl/tam_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tam_pkg.
module tam_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tam_pkg::t_div_req i_req,
    output tam_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic                             r_neg;
    logic [tam_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [tam_pkg::CNT_W-1:0]        r_rem;
    logic [tam_pkg::CNT_W-1:0]        r_den;
    logic [tam_pkg::TRIM_W-1:0]       r_quo;

    logic [tam_pkg::TRIM_W-1:0]       w_abs;
    logic [tam_pkg::CNT_W:0]          w_try;
    logic [tam_pkg::CNT_W:0]          w_sub;
    logic                             w_ge;
    logic [tam_pkg::CNT_W-1:0]        n_rem;
    logic [tam_pkg::TRIM_W-1:0]       n_quo;
    logic [tam_pkg::TRIM_W-1:0]       w_qs;

    assign w_abs = i_req.dividend[tam_pkg::TRIM_W-1] ?
                   tam_pkg::TRIM_W'(-i_req.dividend) : tam_pkg::TRIM_W'(i_req.dividend);
    assign w_try = {r_rem, r_quo[tam_pkg::TRIM_W-1]};
    assign w_ge  = w_try >= {1'b0, r_den};
    assign w_sub = w_try - {1'b0, r_den};
    assign n_rem = w_ge ? w_sub[tam_pkg::CNT_W-1:0] : w_try[tam_pkg::CNT_W-1:0];
    assign n_quo = {r_quo[tam_pkg::TRIM_W-2:0], w_ge};
    assign w_qs  = r_neg ? (~r_quo + tam_pkg::TRIM_W'(1)) : r_quo;

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = w_qs[tam_pkg::OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy &&
                      (r_cnt == tam_pkg::DIV_CNT_W'(tam_pkg::TRIM_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_abs;
                r_neg  <= i_req.dividend[tam_pkg::TRIM_W-1];
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + tam_pkg::DIV_CNT_W'(1);
                if (r_cnt == tam_pkg::DIV_CNT_W'(tam_pkg::TRIM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/tam_scale.sv
// Two-stage milli-g scaler: value * gain / 32768 toward zero, saturated to 19 bits.
// Depends on tam_pkg.
module tam_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [tam_pkg::OUT_W-1:0] i_value,
    input  logic [tam_pkg::GAIN_W-1:0]       i_gain,
    output logic                             o_done,
    output logic signed [tam_pkg::OUT_W-1:0] o_result
);

    logic                              r_v1;
    logic                              r_v2;
    logic signed [tam_pkg::PROD_W-1:0] r_prod;
    logic signed [tam_pkg::OUT_W-1:0]  r_result;

    logic signed [tam_pkg::GAIN_W:0]   w_gain_s;
    logic signed [tam_pkg::PROD_W-1:0] w_bias;
    logic signed [tam_pkg::PROD_W-1:0] w_shift;
    logic signed [tam_pkg::PROD_W-1:0] w_sat;

    assign w_gain_s = {1'b0, i_gain};
    assign w_bias   = r_prod + (r_prod[tam_pkg::PROD_W-1] ? tam_pkg::MG_ROUND : '0);
    assign w_shift  = w_bias >>> tam_pkg::MG_SHIFT;
    assign w_sat    = (w_shift > tam_pkg::SAT_HI) ? tam_pkg::SAT_HI :
                      (w_shift < tam_pkg::SAT_LO) ? tam_pkg::SAT_LO : w_shift;

    assign o_done   = r_v2;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            if (i_start) begin
                r_prod <= tam_pkg::PROD_W'(i_value) * tam_pkg::PROD_W'(w_gain_s);
            end
            if (r_v1) begin
                r_result <= w_sat[tam_pkg::OUT_W-1:0];
            end
        end
    end

endmodule

>>> rtl/three_axis_trimmed_mean.sv
// Three-axis trimmed-mean accelerometer monitor: window accumulation, sequencer, output stage.
// Depends on tam_pkg, tam_div and tam_scale.
//
// A sample item (tuser 0) is accepted, then handled one axis at a time through the
// shared magnitude-compare and accumulate path. A report item (tuser 1) with fewer than three
// samples in the window goes straight to the output stage. Otherwise it is accepted, then per
// axis one signed division of 28 quotient bits runs at one bit per cycle, then six
// passes go through the shared scaling multiplier (three means, three peaks),
// then the output register is loaded. The input is not ready while an item is being
// worked on. A result sits in the output register until taken; samples
// are accepted meanwhile, and a following report waits for that register before it finishes.
// The window restarts after every report and when a sample arrives on a full window.
module three_axis_trimmed_mean (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tam_pkg::CFG_W-1:0]          i_cfg_data,     // full_scale_g
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [tam_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata, // accel_x, accel_y, accel_z
    input  logic                               i_s_axis_tuser, // mode
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // mean_x, mean_y, mean_z, peak_x, peak_y, peak_z, zero fill
    output logic [tam_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tuser  // too_few_samples
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_EMIT
    } t_state;

    t_state                                r_state;
    logic [1:0]                            r_axis;
    logic [2:0]                            r_op;
    logic                                  r_first;
    logic [tam_pkg::GAIN_W-1:0]            r_gain;
    logic [tam_pkg::CNT_W-1:0]             r_count;
    logic signed [tam_pkg::SUM_W-1:0]      r_sum [3];
    logic signed [tam_pkg::SMP_W-1:0]      r_max [3];
    logic signed [tam_pkg::SMP_W-1:0]      r_min [3];
    logic signed [tam_pkg::SMP_W-1:0]      r_smp [3];
    logic signed [tam_pkg::OUT_W-1:0]      r_q   [3];
    logic signed [tam_pkg::OUT_W-1:0]      r_res [6];
    logic                                  r_tf;
    logic signed [tam_pkg::OUT_W-1:0]      r_out [6];
    logic                                  r_out_tf;
    logic                                  r_m_valid;

    logic                                  w_s_acc;
    logic                                  w_m_acc;
    logic signed [tam_pkg::SMP_W-1:0]      w_s;
    logic signed [tam_pkg::SMP_W-1:0]      w_cmax;
    logic signed [tam_pkg::SMP_W-1:0]      w_cmin;
    logic [tam_pkg::SMP_W:0]               w_mag_s;
    logic [tam_pkg::SMP_W:0]               w_mag_max;
    logic [tam_pkg::SMP_W:0]               w_mag_min;
    logic signed [tam_pkg::SUM_W-1:0]      w_sum_base;
    logic signed [tam_pkg::SUM_W-1:0]      n_sum;
    logic [1:0]                            w_pk;
    logic signed [tam_pkg::OUT_W-1:0]      w_mul_val;
    tam_pkg::t_div_req                     w_div_req;
    tam_pkg::t_div_rsp                     w_div_rsp;
    logic                                  w_mul_done;
    logic signed [tam_pkg::OUT_W-1:0]      w_mul_res;

    assign o_cfg_ready     = i_rst_n;
    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_out_tf;
    assign o_m_axis_tdata  = {(tam_pkg::OUT_TDATA_W - 6 * tam_pkg::OUT_W)'(0),
                              r_out[5], r_out[4], r_out[3], r_out[2], r_out[1], r_out[0]};

    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_acc = r_m_valid && i_m_axis_tready;

    // shared per-axis update path
    assign w_s        = r_smp[r_axis];
    assign w_cmax     = r_max[r_axis];
    assign w_cmin     = r_min[r_axis];
    assign w_mag_s    = tam_pkg::mag16(w_s);
    assign w_mag_max  = tam_pkg::mag16(w_cmax);
    assign w_mag_min  = tam_pkg::mag16(w_cmin);
    assign w_sum_base = r_first ? '0 : r_sum[r_axis];
    assign n_sum      = w_sum_base +
                        {{(tam_pkg::SUM_W - tam_pkg::SMP_W){w_s[tam_pkg::SMP_W-1]}}, w_s};

    assign w_div_req.start    = (r_state == ST_DIV_START);
    assign w_div_req.dividend =
        {r_sum[r_axis][tam_pkg::SUM_W-1], r_sum[r_axis]}
        - {{(tam_pkg::TRIM_W - tam_pkg::SMP_W){w_cmax[tam_pkg::SMP_W-1]}}, w_cmax}
        - {{(tam_pkg::TRIM_W - tam_pkg::SMP_W){w_cmin[tam_pkg::SMP_W-1]}}, w_cmin};
    assign w_div_req.divisor  = r_count - tam_pkg::CNT_W'(2);

    assign w_pk      = 2'(r_op - 3'd3);
    assign w_mul_val = (r_op < 3'd3) ? r_q[r_op[1:0]] :
                       {{(tam_pkg::OUT_W - tam_pkg::SMP_W){r_max[w_pk][tam_pkg::SMP_W-1]}},
                        r_max[w_pk]};

    tam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    tam_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == ST_MUL_START),
        .i_value  (w_mul_val),
        .i_gain   (r_gain),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gain    <= tam_pkg::GAIN_W'(tam_pkg::FS_RESET * tam_pkg::MG_NUM);
            r_count   <= '0;
            r_m_valid <= 1'b0;
            r_axis    <= '0;
            r_op      <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
                r_max[a] <= '0;
                r_min[a] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain <= tam_pkg::GAIN_W'(i_cfg_data) * tam_pkg::GAIN_W'(tam_pkg::MG_NUM);
            end
            if (w_m_acc && (r_state != ST_EMIT)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    r_axis <= '0;
                    r_op   <= '0;
                    if (w_s_acc) begin
                        if (!i_s_axis_tuser) begin
                            r_smp[0] <= i_s_axis_tdata[tam_pkg::SMP_W-1:0];
                            r_smp[1] <= i_s_axis_tdata[2*tam_pkg::SMP_W-1:tam_pkg::SMP_W];
                            r_smp[2] <= i_s_axis_tdata[3*tam_pkg::SMP_W-1:2*tam_pkg::SMP_W];
                            r_first  <= (r_count == '0) ||
                                        (r_count == tam_pkg::CNT_W'(tam_pkg::WINDOW));
                            r_state  <= ST_SAMPLE;
                        end else if (r_count < tam_pkg::CNT_W'(tam_pkg::MIN_SAMPLES)) begin
                            for (int k = 0; k < 6; k++) begin
                                r_res[k] <= '0;
                            end
                            r_tf    <= 1'b1;
                            r_state <= ST_EMIT;
                        end else begin
                            r_tf    <= 1'b0;
                            r_state <= ST_DIV_START;
                        end
                    end
                end
                ST_SAMPLE: begin
                    r_sum[r_axis] <= n_sum;
                    if (r_first) begin
                        r_max[r_axis] <= w_s;
                        r_min[r_axis] <= w_s;
                    end else if (w_mag_s > w_mag_max) begin
                        r_max[r_axis] <= w_s;
                    end else if (w_mag_s < w_mag_min) begin
                        r_min[r_axis] <= w_s;
                    end
                    if (r_axis == 2'd2) begin
                        r_count <= r_first ? tam_pkg::CNT_W'(1) : r_count + tam_pkg::CNT_W'(1);
                        r_state <= ST_IDLE;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                ST_DIV_START: begin
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_q[r_axis] <= w_div_rsp.quotient;
                        if (r_axis == 2'd2) begin
                            r_state <= ST_MUL_START;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= ST_DIV_START;
                        end
                    end
                end
                ST_MUL_START: begin
                    r_state <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (w_mul_done) begin
                        r_res[r_op] <= w_mul_res;
                        if (r_op == 3'd5) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_op    <= r_op + 3'd1;
                            r_state <= ST_MUL_START;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        for (int k = 0; k < 6; k++) begin
                            r_out[k] <= r_res[k];
                        end
                        r_out_tf  <= r_tf;
                        r_m_valid <= 1'b1;
                        r_count   <= '0;
                        for (int a = 0; a < 3; a++) begin
                            r_sum[a] <= '0;
                            r_max[a] <= '0;
                            r_min[a] <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tam_pkg::CNT_W'(tam_pkg::WINDOW))
        else $error("sample count beyond window");

    a_sample_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !i_s_axis_tuser) |=> (r_state == ST_SAMPLE && r_axis == 2'd0))
        else $error("sample item did not start axis pass");

    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && i_s_axis_tuser) |=> !o_s_axis_tready)
        else $error("report item left block ready");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("too-few result carries nonzero data");

endmodule

>>> tb/sv/three_axis_trimmed_mean_tb.sv
// Self-checking testbench for three_axis_trimmed_mean: drives sample and report items,
// predicts each report with its own window model or a directed value and compares it field by field.
// Depends on tam_pkg and the three_axis_trimmed_mean RTL.
module three_axis_trimmed_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [tam_pkg::OUT_W-1:0] mean_x, mean_y, mean_z;
        logic signed [tam_pkg::OUT_W-1:0] peak_x, peak_y, peak_z;
        logic                             too_few;
    } t_report;

    typedef struct packed {
        logic                             mode;
        logic signed [tam_pkg::SMP_W-1:0] ax, ay, az;
        logic                             typed;
        t_report                          want;
    } t_accel_item;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_REPORT = 1'b1;
    localparam longint OUT_TOP = (longint'(1) << (tam_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_BOT = -OUT_TOP - 1;
    localparam int DRAIN_CYCLES = 200;

    localparam t_report SHORT_WINDOW = '{too_few: 1'b1, default: '0};
    // three full-negative X, full-positive Y, zero Z samples at 2 g
    localparam t_report FS2_EXTREMES = '{
        mean_x: -19'sd20000, mean_y: 19'sd19999, mean_z: 19'sd0,
        peak_x: -19'sd20000, peak_y: 19'sd19999, peak_z: 19'sd0,
        too_few: 1'b0};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tam_pkg::CFG_W-1:0]       i_cfg_data = tam_pkg::CFG_W'(tam_pkg::FS_RESET);
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [tam_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // accel_x, accel_y, accel_z
    logic                            i_s_axis_tuser = 1'b0; // mode
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [tam_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;        // mean_x..z, peak_x..z, zero fill
    logic                            o_m_axis_tuser;        // too_few_samples

    longint  fs_gain = longint'(tam_pkg::FS_RESET);
    int      win_count = 0;
    longint  win_sum [3];
    int      win_max [3];
    int      win_min [3];
    t_report reports_due [$];
    int      mismatches = 0;
    int      snd_idle_pct = 0;
    int      rcv_idle_pct = 0;

    three_axis_trimmed_mean uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void clear_window();
        win_count = 0;
        for (int a = 0; a < 3; a++) begin
            win_sum[a] = 0;
            win_max[a] = 0;
            win_min[a] = 0;
        end
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [tam_pkg::OUT_W-1:0] to_milli_g(input longint v);
        longint r;
        r = (v * fs_gain * longint'(tam_pkg::MG_NUM)) / longint'(32768);
        if (r > OUT_TOP) r = OUT_TOP;
        if (r < OUT_BOT) r = OUT_BOT;
        return r[tam_pkg::OUT_W-1:0];
    endfunction

    task automatic advance_window(input t_accel_item it, output bit has_rep,
                                  output t_report rep);
        int                               smp [3];
        logic signed [tam_pkg::OUT_W-1:0] mean [3];
        logic signed [tam_pkg::OUT_W-1:0] peak [3];
        longint                           trimmed;
        smp[0] = int'(it.ax);
        smp[1] = int'(it.ay);
        smp[2] = int'(it.az);
        has_rep = 1'b0;
        rep = '0;
        if (it.mode == MODE_SAMPLE) begin
            if (win_count >= tam_pkg::WINDOW) clear_window();
            for (int a = 0; a < 3; a++) begin
                if (win_count == 0) begin
                    win_max[a] = smp[a];
                    win_min[a] = smp[a];
                end else if (magnitude(smp[a]) > magnitude(win_max[a])) begin
                    win_max[a] = smp[a];
                end else if (magnitude(smp[a]) < magnitude(win_min[a])) begin
                    win_min[a] = smp[a];
                end
                win_sum[a] += longint'(smp[a]);
            end
            win_count++;
        end else begin
            has_rep = 1'b1;
            if (win_count < tam_pkg::MIN_SAMPLES) begin
                rep = SHORT_WINDOW;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    trimmed = win_sum[a] - longint'(win_max[a]) - longint'(win_min[a]);
                    mean[a] = to_milli_g(trimmed / longint'(win_count - 2));
                    peak[a] = to_milli_g(longint'(win_max[a]));
                end
                rep.mean_x = mean[0];
                rep.mean_y = mean[1];
                rep.mean_z = mean[2];
                rep.peak_x = peak[0];
                rep.peak_y = peak[1];
                rep.peak_z = peak[2];
                rep.too_few = 1'b0;
            end
            clear_window();
        end
    endtask

    function automatic t_accel_item sample_item(input logic signed [tam_pkg::SMP_W-1:0] x,
                                                y, z);
        t_accel_item it;
        it = '0;
        it.mode = MODE_SAMPLE;
        it.ax = x;
        it.ay = y;
        it.az = z;
        return it;
    endfunction

    // report items carry random sample fields, which the block must ignore
    function automatic t_accel_item report_item();
        t_accel_item it;
        it = '0;
        it.mode = MODE_REPORT;
        it.ax = tam_pkg::SMP_W'($urandom);
        it.ay = tam_pkg::SMP_W'($urandom);
        it.az = tam_pkg::SMP_W'($urandom);
        return it;
    endfunction

    function automatic t_accel_item report_typed(input t_report want);
        t_accel_item it;
        it = report_item();
        it.typed = 1'b1;
        it.want = want;
        return it;
    endfunction

    function automatic logic signed [tam_pkg::SMP_W-1:0] rand_accel();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd0;
            3, 4:    return tam_pkg::SMP_W'($urandom_range(0, 40)) - 16'sd20;
            default: return tam_pkg::SMP_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_accel_item it);
        bit      has_rep;
        t_report rep;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.az, it.ay, it.ax};
        i_s_axis_tuser  <= it.mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        advance_window(it, has_rep, rep);
        if (has_rep) reports_due.push_back(it.typed ? it.want : rep);
    endtask

    task automatic send_window(input int n_smp);
        repeat (n_smp) send_item(sample_item(rand_accel(), rand_accel(), rand_accel()));
        send_item(report_item());
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_full_scale(input logic [tam_pkg::CFG_W-1:0] fs);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fs;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        fs_gain = longint'(fs);
    endtask

    // mostly windows of three to twelve samples, some with fewer than three samples
    task automatic run_segment(input logic [tam_pkg::CFG_W-1:0] fs,
                               input int snd_pct, rcv_pct, input int n_items);
        int sent;
        int n;
        drain();
        write_full_scale(fs);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_items) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            send_window(n);
            sent += n + 1;
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic signed [tam_pkg::OUT_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.mean_x  = o_m_axis_tdata[0 * tam_pkg::OUT_W +: tam_pkg::OUT_W];
            got.mean_y  = o_m_axis_tdata[1 * tam_pkg::OUT_W +: tam_pkg::OUT_W];
            got.mean_z  = o_m_axis_tdata[2 * tam_pkg::OUT_W +: tam_pkg::OUT_W];
            got.peak_x  = o_m_axis_tdata[3 * tam_pkg::OUT_W +: tam_pkg::OUT_W];
            got.peak_y  = o_m_axis_tdata[4 * tam_pkg::OUT_W +: tam_pkg::OUT_W];
            got.peak_z  = o_m_axis_tdata[5 * tam_pkg::OUT_W +: tam_pkg::OUT_W];
            got.too_few = o_m_axis_tuser;
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected report, expected none got %h", $time, got);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("mean_x", want.mean_x, got.mean_x);
                check_field("mean_y", want.mean_y, got.mean_y);
                check_field("mean_z", want.mean_z, got.mean_z);
                check_field("peak_x", want.peak_x, got.peak_x);
                check_field("peak_y", want.peak_y, got.peak_y);
                check_field("peak_z", want.peak_z, got.peak_z);
                check_field("too_few_samples", tam_pkg::OUT_W'(want.too_few),
                            tam_pkg::OUT_W'(got.too_few));
            end
        end
    end

    initial begin
        t_accel_item directed [$];
        clear_window();

        // at the reset full scale of 2 g
        directed.push_back(report_typed(SHORT_WINDOW));             // empty window
        directed.push_back(sample_item(16'sh7FFF, 16'sh8000, 16'sd0));
        directed.push_back(report_typed(SHORT_WINDOW));             // one sample
        repeat (3) directed.push_back(sample_item(16'sh8000, 16'sh7FFF, 16'sd0));
        directed.push_back(report_typed(FS2_EXTREMES));
        directed.push_back(sample_item(16'sd1, -16'sd1, 16'sd0));
        directed.push_back(sample_item(-16'sd1, 16'sd1, 16'sd0));
        directed.push_back(report_typed(SHORT_WINDOW));             // two samples
        directed.push_back(report_typed(SHORT_WINDOW));             // back-to-back report
        // equal magnitudes of both signs, -32768 against 32767
        directed.push_back(sample_item(16'sd5, -16'sd5, 16'sd100));
        directed.push_back(sample_item(-16'sd5, 16'sd5, -16'sd100));
        directed.push_back(sample_item(16'sd3, -16'sd200, 16'sd0));
        directed.push_back(sample_item(16'sh8000, 16'sh7FFF, 16'sd1));
        directed.push_back(sample_item(16'sd0, 16'sd0, 16'sh8000));
        directed.push_back(sample_item(16'sd2, -16'sd2, 16'sh7FFF));
        directed.push_back(report_item());
        // negative means truncate toward zero
        directed.push_back(sample_item(16'sd1, 16'sd2, 16'sd3));
        directed.push_back(sample_item(-16'sd1, -16'sd2, -16'sd3));
        directed.push_back(sample_item(-16'sd7, 16'sd8, -16'sd9));
        directed.push_back(sample_item(-16'sd4, -16'sd3, 16'sd2));
        directed.push_back(report_item());
        directed.push_back(report_typed(SHORT_WINDOW));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_item(directed[k]);

        run_segment(tam_pkg::CFG_W'(16), 12, 82, 130);
        run_segment(tam_pkg::CFG_W'(1), 82, 12, 130);
        run_segment(tam_pkg::CFG_W'(0), 0, 0, 130);
        run_segment(tam_pkg::CFG_W'(31), 0, 0, 130);    // saturates the milli-g outputs
        run_segment(tam_pkg::CFG_W'($urandom_range(2, 15)), 0, 0, 130);

        drain();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tam_pkg.sv
rtl/tam_div.sv
rtl/tam_scale.sv
rtl/three_axis_trimmed_mean.sv
tb/sv/three_axis_trimmed_mean_tb.sv
